// ----- sv/pftc_pkg.sv -----
// pftc_pkg: types and constants for the permutation FDR threshold counter.
// No dependencies.
package pftc_pkg;
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_OBS  = 2'd1,
    OP_PERM = 2'd2,
    OP_READ = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_TWO_SIDED = 2'd0,
    MODE_GREATER   = 2'd1,
    MODE_LESS      = 2'd2,
    MODE_NONE      = 2'd3
  } mode_t;

  localparam logic CFG_MODE      = 1'b0;
  localparam logic CFG_NUM_PERMS = 1'b1;

  localparam int OBS_W  = 20;
  localparam int PERM_W = 32;
  localparam int VAL_W  = 32;
  localparam int IDX_W  = 7;
  localparam int FDR_W  = 32;
  localparam int NP_W   = 16;
  localparam logic [FDR_W-1:0] FDR_MAX = '1;

  // pass test on 33-bit exact arithmetic
  function automatic logic passes(input logic [1:0] mode, input logic signed [31:0] v,
                                  input logic signed [31:0] c);
    logic signed [32:0] x;
    logic signed [32:0] cc;
    logic signed [32:0] ax;
    x  = {v[31], v};
    cc = {c[31], c};
    ax = x[32] ? -x : x;
    case (mode)
      MODE_TWO_SIDED: passes = ax > cc;
      MODE_GREATER:   passes = x > cc;
      MODE_LESS:      passes = x < -cc;
      default:        passes = 1'b0;
    endcase
  endfunction
endpackage

// ----- sv/pftc_ram.sv -----
// pftc_ram: generic single-port-write, single-read synchronous RAM.
// Registered read. No dependencies.
module pftc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/pftc_div.sv -----
// pftc_div: restoring divider, one quotient bit per cycle, saturating to 32 bits.
// Depends on pftc_pkg.
module pftc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pftc_pkg::PERM_W-1:0]   perm,
  input  logic [pftc_pkg::NP_W+pftc_pkg::OBS_W-1:0] den,
  output logic                          done,
  output logic [pftc_pkg::FDR_W-1:0]    quot
);
  localparam int NW = pftc_pkg::PERM_W + 16;
  localparam int DW = pftc_pkg::NP_W + pftc_pkg::OBS_W;
  logic [NW-1:0] num_r, num_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW+1:0] trial;
  logic [DW:0]   sh;

  always_comb begin
    num_nxt = num_r; rem_nxt = rem_r; q_nxt = q_r; den_nxt = den_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r;
    sh = {rem_r[DW-1:0], num_r[NW-1]};
    trial = {1'b0, sh} - {2'b00, den_r};
    if (start) begin
      num_nxt = {perm, 16'h0000}; rem_nxt = '0; q_nxt = '0; den_nxt = den;
      cnt_nxt = 6'(NW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = num_r << 1;
      if (!trial[DW+1]) begin
        rem_nxt = trial[DW:0]; q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = sh; q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0; done <= 1'b0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
      done <= busy_r && cnt_r == 6'd1;
    end
    num_r <= num_nxt; rem_r <= rem_nxt; q_r <= q_nxt; den_r <= den_nxt;
  end

  assign quot = (|q_r[NW-1:pftc_pkg::FDR_W]) ? pftc_pkg::FDR_MAX : q_r[pftc_pkg::FDR_W-1:0];
endmodule

// ----- sv/permutation_fdr_threshold_counter.sv -----
// permutation_fdr_threshold_counter: top level. Cutpoints and counters live in RAMs.
// Depends on pftc_pkg, pftc_ram, pftc_div.
//
//  channel | dir | fields
//  in_     | in  | opcode, cut_index, value
//  out_    | out | result_index, observed_count, permuted_count, fdr, no_calls
//  cfg_    | in  | index, data
//
// Load: taken in its accept cycle, input ready again on the next cycle.
// Observed/permuted: busy after accept while the scan walks all cutpoints, one cutpoint entry
// per cycle through the counter RAM read-modify-write. Read: busy for the RAM read and the
// divider (one quotient bit per cycle); the divider is skipped when there are no calls.
// Reset synchronous, clears valid bits.
// Input is stalled while an item is in work or the output word is unread.
module permutation_fdr_threshold_counter #(
  parameter int MAX_CUTS  = 128,
  parameter int MAX_GENES = 1048575
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_opcode,
  input  logic [pftc_pkg::IDX_W-1:0]     in_cut_index,
  input  logic signed [pftc_pkg::VAL_W-1:0] in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pftc_pkg::IDX_W-1:0]     out_result_index,
  output logic [pftc_pkg::OBS_W-1:0]     out_observed_count,
  output logic [pftc_pkg::PERM_W-1:0]    out_permuted_count,
  output logic [pftc_pkg::FDR_W-1:0]     out_fdr,
  output logic                           out_no_calls,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [15:0]                    cfg_data
);
  localparam int AW = $clog2(MAX_CUTS);
  localparam int CW = AW + 1;
  localparam int CNT_W = pftc_pkg::OBS_W + pftc_pkg::PERM_W;
  localparam logic [pftc_pkg::OBS_W-1:0] OBS_LIM =
    (MAX_GENES < 1048575) ? pftc_pkg::OBS_W'(MAX_GENES) : '1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_RD   = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0]  mode_r;
  logic [15:0] np_r;
  logic [MAX_CUTS-1:0] vld_r;
  logic [7:0]  lcnt_r;
  logic        obs_r;
  logic signed [31:0] val_r;
  logic [pftc_pkg::IDX_W-1:0] idx_r;
  logic        oor_r;
  logic [CW-1:0] rp_r;
  logic        s1_v_r;
  logic [AW-1:0] s1_a_r;

  logic cut_we, cnt_we;
  logic [AW-1:0] cut_wa, cnt_wa, rd_a;
  logic [31:0] cut_wd, cut_rd;
  logic [CNT_W-1:0] cnt_wd, cnt_rd;
  logic div_start, div_done;
  logic [pftc_pkg::FDR_W-1:0] div_q;
  logic [pftc_pkg::OBS_W-1:0] obs_v;
  logic [pftc_pkg::PERM_W-1:0] perm_v;
  logic [15:0] npe;
  logic [pftc_pkg::OBS_W+15:0] den;
  logic in_acc, ld_ok, hit;

  assign in_ready  = state_r == S_IDLE;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign ld_ok     = 32'(in_cut_index) < 32'(MAX_CUTS);

  assign obs_v  = cnt_rd[CNT_W-1:pftc_pkg::PERM_W];
  assign perm_v = cnt_rd[pftc_pkg::PERM_W-1:0];
  assign npe    = (np_r == 16'd0) ? 16'd1 : np_r;
  assign den    = npe * obs_v;

  assign rd_a = (state_r == S_IDLE) ? AW'(in_cut_index) : rp_r[AW-1:0];
  assign hit  = s1_v_r && vld_r[s1_a_r] && pftc_pkg::passes(mode_r, val_r, cut_rd);

  always_comb begin
    cut_we = in_acc && in_opcode == pftc_pkg::OP_LOAD && ld_ok;
    cut_wa = AW'(in_cut_index);
    cut_wd = in_value;
    cnt_we = cut_we;
    cnt_wa = AW'(in_cut_index);
    cnt_wd = '0;
    if (state_r == S_SCAN && hit) begin
      cnt_we = 1'b1;
      cnt_wa = s1_a_r;
      cnt_wd = cnt_rd;
      if (obs_r) begin
        if (obs_v < OBS_LIM) cnt_wd[CNT_W-1:pftc_pkg::PERM_W] = obs_v + 1'b1;
      end else if (perm_v != '1) begin
        cnt_wd[pftc_pkg::PERM_W-1:0] = perm_v + 1'b1;
      end
    end
  end

  pftc_ram #(.WIDTH(32), .DEPTH(MAX_CUTS)) u_cut (
    .clk(clk), .we(cut_we), .waddr(cut_wa), .wdata(cut_wd), .raddr(rd_a), .rdata(cut_rd));
  pftc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_CUTS)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd), .raddr(rd_a), .rdata(cnt_rd));

  assign div_start = state_r == S_RD && !oor_r && vld_r[s1_a_r] && obs_v != '0;
  pftc_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .perm(perm_v), .den(den),
    .done(div_done), .quot(div_q));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) begin
        case (in_opcode)
          pftc_pkg::OP_OBS, pftc_pkg::OP_PERM: state_nxt = S_SCAN;
          pftc_pkg::OP_READ: state_nxt = S_RD;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SCAN: if (!s1_v_r && rp_r == CW'(MAX_CUTS)) state_nxt = S_IDLE;
      S_RD:   state_nxt = div_start ? S_DIV : S_OUT;
      S_DIV:  if (div_done) state_nxt = S_OUT;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = state_r == S_OUT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; mode_r <= 2'd0; np_r <= 16'd1; vld_r <= '0; lcnt_r <= '0;
      s1_v_r <= 1'b0; rp_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pftc_pkg::CFG_MODE) mode_r <= cfg_data[1:0];
        else np_r <= cfg_data;
      end
      if (cut_we) begin
        vld_r[AW'(in_cut_index)] <= 1'b1;
        if (!vld_r[AW'(in_cut_index)] && lcnt_r != 8'hFF) lcnt_r <= lcnt_r + 8'd1;
      end
      if (state_r == S_IDLE) begin
        s1_v_r <= 1'b0;
        rp_r <= in_acc && (in_opcode == pftc_pkg::OP_OBS || in_opcode == pftc_pkg::OP_PERM)
                ? '0 : CW'(MAX_CUTS);
      end else if (state_r == S_SCAN) begin
        s1_v_r <= rp_r < CW'(MAX_CUTS);
        s1_a_r <= rp_r[AW-1:0];
        if (rp_r < CW'(MAX_CUTS)) rp_r <= rp_r + 1'b1;
      end
    end
    if (in_acc) begin
      obs_r <= in_opcode == pftc_pkg::OP_OBS;
      val_r <= in_value;
      idx_r <= in_cut_index;
      oor_r <= !ld_ok;
      if (in_opcode == pftc_pkg::OP_READ) s1_a_r <= AW'(in_cut_index);
    end
    if (state_r == S_RD) begin
      out_result_index <= idx_r;
      out_observed_count <= (oor_r || !vld_r[s1_a_r]) ? '0 : obs_v;
      out_permuted_count <= (oor_r || !vld_r[s1_a_r]) ? '0 : perm_v;
      out_fdr <= pftc_pkg::FDR_MAX;
      out_no_calls <= !div_start;
    end
    if (state_r == S_DIV && div_done) out_fdr <= div_q;
  end

  // scan walks entries in order while busy
  a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN && rp_r < CW'(MAX_CUTS) |=> rp_r == $past(rp_r) + 1'b1)
    else $error("scan pointer skipped");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fdr))
    else $error("result dropped");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready)
    else $error("input taken while busy");
  a_nocalls: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_calls |-> out_fdr == pftc_pkg::FDR_MAX)
    else $error("no_calls without saturated fdr");
endmodule

// ----- sim/permutation_fdr_threshold_counter_test.sv -----
// Self-checking bench for permutation_fdr_threshold_counter: queued words are
// driven in, read words are checked against an in-bench cutpoint/counter model.
// Depends on pftc_pkg and the block's RTL.
`timescale 1ns / 100ps

module permutation_fdr_threshold_counter_test;

  localparam int NCUTS    = 128;
  localparam int OBS_LIM  = 1048575;
  localparam int WD_LIMIT = 5000;
  localparam int SETTLE   = 200;

  typedef struct packed {
    pftc_pkg::opcode_t          op;
    logic [pftc_pkg::IDX_W-1:0] idx;
    logic [pftc_pkg::VAL_W-1:0] val;
  } word_t;

  typedef struct packed {
    logic [pftc_pkg::IDX_W-1:0]  idx;
    logic [pftc_pkg::OBS_W-1:0]  obs;
    logic [pftc_pkg::PERM_W-1:0] perm;
    logic [pftc_pkg::FDR_W-1:0]  fdr;
    logic                        nc;
  } readout_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_opcode = '0;
  logic [pftc_pkg::IDX_W-1:0] in_cut_index = '0;
  logic signed [pftc_pkg::VAL_W-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [pftc_pkg::IDX_W-1:0] out_result_index;
  logic [pftc_pkg::OBS_W-1:0] out_observed_count;
  logic [pftc_pkg::PERM_W-1:0] out_permuted_count;
  logic [pftc_pkg::FDR_W-1:0] out_fdr;
  logic out_no_calls;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  permutation_fdr_threshold_counter i_dut (.*);

  always #5 clk = ~clk;

  word_t    pending_words[$];
  readout_t expected_reads[$];

  // model state
  pftc_pkg::mode_t            cur_mode = pftc_pkg::MODE_TWO_SIDED;
  logic [pftc_pkg::NP_W-1:0]  cur_perms = 16'd1;
  logic signed [31:0] cut_val[NCUTS];
  bit               cut_loaded[NCUTS];
  int unsigned      obs_cnt[NCUTS];
  int unsigned      perm_cnt[NCUTS];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_len = 0;
  int  hold_left = 0;
  bit  in_taken = 1'b0;
  int  errors = 0;
  int  words_in = 0;
  int  reads_out = 0;
  int  idle_cycles = 0;

  function automatic bit beats_cut(pftc_pkg::mode_t m, logic signed [31:0] v,
                                   logic signed [31:0] c);
    longint x;
    longint cc;
    x  = v;
    cc = c;
    case (m)
      pftc_pkg::MODE_TWO_SIDED: return (x < 0 ? -x : x) > cc;
      pftc_pkg::MODE_GREATER:   return x > cc;
      pftc_pkg::MODE_LESS:      return x < -cc;
      default:                  return 1'b0;
    endcase
  endfunction

  task automatic apply_word(word_t w);
    readout_t r;
    longint unsigned den;
    longint unsigned q;
    case (w.op)
      pftc_pkg::OP_LOAD: begin
        cut_loaded[w.idx] = 1'b1;
        cut_val[w.idx] = w.val;
        obs_cnt[w.idx] = 0;
        perm_cnt[w.idx] = 0;
      end
      pftc_pkg::OP_OBS, pftc_pkg::OP_PERM: begin
        for (int i = 0; i < NCUTS; i++) begin
          if (cut_loaded[i] && beats_cut(cur_mode, w.val, cut_val[i])) begin
            if (w.op == pftc_pkg::OP_OBS) begin
              if (obs_cnt[i] < OBS_LIM) obs_cnt[i]++;
            end else if (perm_cnt[i] != 32'hFFFF_FFFF) begin
              perm_cnt[i]++;
            end
          end
        end
      end
      default: begin
        r.idx = w.idx;
        r.obs = pftc_pkg::OBS_W'(obs_cnt[w.idx]);
        r.perm = perm_cnt[w.idx];
        r.fdr = pftc_pkg::FDR_MAX;
        r.nc = 1'b1;
        if (obs_cnt[w.idx] != 0) begin
          den = (cur_perms == 0 ? 64'd1 : 64'(cur_perms)) * 64'(obs_cnt[w.idx]);
          q = (64'(perm_cnt[w.idx]) << 16) / den;
          r.fdr = q > 64'hFFFF_FFFF ? pftc_pkg::FDR_MAX : q[31:0];
          r.nc = 1'b0;
        end
        expected_reads.push_back(r);
      end
    endcase
  endtask

  task automatic chk(string fld, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fld, exp_v, act_v);
      errors++;
    end
  endtask

  // monitor: input acceptance feeds the model, read words are checked
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        apply_word('{pftc_pkg::opcode_t'(in_opcode), in_cut_index, in_value});
        words_in++;
      end
      if (out_valid && out_ready) begin
        reads_out++;
        if (expected_reads.size() == 0) begin
          $display("%0t: unexpected read word, index %0d", $time, out_result_index);
          errors++;
        end else begin
          readout_t e;
          e = expected_reads.pop_front();
          chk("result_index", 32'(e.idx), 32'(out_result_index));
          chk("observed_count", 32'(e.obs), 32'(out_observed_count));
          chk("permuted_count", e.perm, out_permuted_count);
          chk("fdr", e.fdr, out_fdr);
          chk("no_calls", 32'(e.nc), 32'(out_no_calls));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) ||
        !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WD_LIMIT);
      $display("permutation_fdr_threshold_counter test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        word_t w;
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        in_opcode <= w.op;
        in_cut_index <= w.idx;
        in_value <= w.val;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver with optional long hold-off
  always @(negedge clk) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(logic idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == pftc_pkg::CFG_MODE) cur_mode = pftc_pkg::mode_t'(data[1:0]);
    else cur_perms = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    while (pending_words.size() != 0 || in_valid || expected_reads.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_stat();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(32'h0004_0000) ^ {32{$urandom_range(1) == 1}};
      default: return $signed($urandom_range(12 << 16)) - (6 << 16);
    endcase
  endfunction

  function automatic logic [31:0] pick_cut();
    case ($urandom_range(5))
      0: return $urandom();
      1: return -$signed($urandom_range(2 << 16));
      default: return $urandom_range(5 << 16);
    endcase
  endfunction

  task automatic queue_random(int n);
    int sel;
    for (int k = 0; k < 12; k++)
      pending_words.push_back('{pftc_pkg::OP_LOAD, 7'($urandom_range(NCUTS - 1)),
                                pick_cut()});
    for (int k = 0; k < n - 12; k++) begin
      sel = $urandom_range(99);
      if (sel < 8)
        pending_words.push_back('{pftc_pkg::OP_LOAD, 7'($urandom_range(NCUTS - 1)),
                                  pick_cut()});
      else if (sel < 45)
        pending_words.push_back('{pftc_pkg::OP_OBS, 7'($urandom()), pick_stat()});
      else if (sel < 82)
        pending_words.push_back('{pftc_pkg::OP_PERM, 7'($urandom()), pick_stat()});
      else
        pending_words.push_back('{pftc_pkg::OP_READ, 7'($urandom_range(NCUTS - 1)),
                                  $urandom()});
    end
  endtask

  initial begin
    for (int i = 0; i < NCUTS; i++) begin
      cut_val[i] = '0;
      cut_loaded[i] = 1'b0;
      obs_cnt[i] = 0;
      perm_cnt[i] = 0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extreme cutpoints and statistics, reads of empty entries
    pending_words.push_back('{pftc_pkg::OP_READ, 7'd127, 32'h0});
    pending_words.push_back('{pftc_pkg::OP_LOAD, 7'd0, 32'h0});
    pending_words.push_back('{pftc_pkg::OP_LOAD, 7'd127, 32'h7FFF_FFFF});
    pending_words.push_back('{pftc_pkg::OP_LOAD, 7'd64, 32'h8000_0000});
    pending_words.push_back('{pftc_pkg::OP_LOAD, 7'd1, 32'hFFFF_FFFF});
    pending_words.push_back('{pftc_pkg::OP_LOAD, 7'd2, 32'h0001_0000});
    pending_words.push_back('{pftc_pkg::OP_OBS, 7'd0, 32'h8000_0000});
    pending_words.push_back('{pftc_pkg::OP_OBS, 7'd127, 32'h7FFF_FFFF});
    pending_words.push_back('{pftc_pkg::OP_OBS, 7'd0, 32'h0});
    pending_words.push_back('{pftc_pkg::OP_OBS, 7'd0, 32'h0001_0001});
    pending_words.push_back('{pftc_pkg::OP_PERM, 7'd0, 32'hFFFF_0000});
    pending_words.push_back('{pftc_pkg::OP_PERM, 7'd0, 32'h8000_0000});
    pending_words.push_back('{pftc_pkg::OP_PERM, 7'd0, 32'h0000_0001});
    for (int i = 0; i < 5; i++)
      pending_words.push_back('{pftc_pkg::OP_READ, 7'(i == 3 ? 64 : i == 4 ? 127 : i),
                                32'hFFFF_FFFF});
    pending_words.push_back('{pftc_pkg::OP_LOAD, 7'd0, 32'h0000_8000});
    pending_words.push_back('{pftc_pkg::OP_READ, 7'd0, 32'h0});
    pending_words.push_back('{pftc_pkg::OP_READ, 7'd5, 32'h0});
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(pftc_pkg::CFG_MODE, 16'(pftc_pkg::MODE_TWO_SIDED));
          write_reg(pftc_pkg::CFG_NUM_PERMS, 16'd1);
        end
        1: begin
          write_reg(pftc_pkg::CFG_MODE, 16'(pftc_pkg::MODE_GREATER));
          write_reg(pftc_pkg::CFG_NUM_PERMS, 16'hFFFF);
        end
        2: begin
          write_reg(pftc_pkg::CFG_MODE, 16'(pftc_pkg::MODE_LESS));
          write_reg(pftc_pkg::CFG_NUM_PERMS, 16'd0);
        end
        3: begin
          write_reg(pftc_pkg::CFG_MODE, 16'(pftc_pkg::MODE_NONE));
          write_reg(pftc_pkg::CFG_NUM_PERMS, 16'd7);
        end
        4: begin
          write_reg(pftc_pkg::CFG_MODE, 16'(pftc_pkg::MODE_TWO_SIDED));
          write_reg(pftc_pkg::CFG_NUM_PERMS, 16'd1000);
        end
        default: begin
          write_reg(pftc_pkg::CFG_MODE, 16'(pftc_pkg::MODE_GREATER));
          write_reg(pftc_pkg::CFG_NUM_PERMS, 16'd3);
        end
      endcase
      send_idle_pct  = (ph == 1) ? 73 : (ph == 3 || ph == 5) ? 10 : 0;
      recv_stall_pct = (ph == 2) ? 73 : (ph == 3 || ph == 5) ? 10 : 0;
      queue_random(130);
      if (ph == 2) begin
        @(posedge clk);
        hold_len = 400;
      end
      if (ph == 4) begin
        // sender waits for every outstanding read word before going on
        while (pending_words.size() != 0 || in_valid || expected_reads.size() != 0)
          @(posedge clk);
      end
      queue_random(125);
      drain();
    end

    $display("Covered %0d input words and %0d read words over all four modes,", words_in,
             reads_out);
    $display("divisors 0, 1, 3, 7, 1000 and 65535, with idle, stall and hold-off phases.");
    if (errors == 0)
      $display("permutation_fdr_threshold_counter test passed");
    else
      $display("permutation_fdr_threshold_counter test failed");
    $finish;
  end

endmodule
